// ===== rtl/pimu_pkg.sv =====
// ----------------------------------------------------------------------------
// pimu_pkg
// Shared constants and types for the packed int8 matrix unpacker.
// ----------------------------------------------------------------------------
package pimu_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_K_W    = 13;
    localparam int CFG_N_W    = 13;
    localparam int CFG_LD_W   = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_K_DEPTH      = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_N_WIDTH      = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LEADING_DIM  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMN_MAJOR = 4'd3;

    localparam int RST_K_DEPTH     = 4;
    localparam int RST_N_WIDTH     = 64;
    localparam int RST_LEADING_DIM = 64;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 28;

    localparam logic [1:0] LANE_LAST = 2'd3;
    localparam logic [3:0] COL_LAST  = 4'hF;

    typedef struct packed {
        logic hit;
        logic last;
    } t_walk_flags;

endpackage

// ===== rtl/pimu_walk.sv =====
// ----------------------------------------------------------------------------
// pimu_walk
// Packed-order traversal counters; gives row, column and hit flags of the
// current byte and steps once per accepted byte.
// ----------------------------------------------------------------------------
module pimu_walk #(
    parameter int KW = 13,
    parameter int NW = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic                  i_advance,
    input  logic [KW-1:0]         i_k_depth,
    input  logic [NW-1:0]         i_n_width,
    output logic [KW-1:0]         o_row,
    output logic [NW:0]           o_col,
    output pimu_pkg::t_walk_flags o_flags
);
    localparam int CW  = NW + 1;
    localparam int DGW = KW - 2;

    logic [1:0]     r_lane, n_lane;
    logic [3:0]     r_cig, n_cig;
    logic [1:0]     r_grp, n_grp;
    logic [DGW-1:0] r_dg, n_dg;
    logic [NW-1:0]  r_ps, n_ps;

    logic [NW-1:0]  w_rem;
    logic [2:0]     w_groups;
    logic [1:0]     w_grp_last;
    logic [KW-1:0]  w_k_m1;
    logic [DGW-1:0] w_dg_last;
    logic [CW-1:0]  w_ps_sum;
    logic [CW-1:0]  w_n_m1;

    assign w_rem = i_n_width - r_ps;

    always_comb begin
        if (w_rem >= NW'(64)) begin
            w_groups = 3'd4;
        end else if (w_rem >= NW'(16)) begin
            w_groups = {1'b0, w_rem[5:4]};
        end else begin
            w_groups = 3'd1;
        end
    end

    assign w_grp_last = 2'(w_groups - 3'd1);
    assign w_k_m1     = i_k_depth - KW'(1);
    assign w_dg_last  = w_k_m1[KW-1:2];
    assign w_ps_sum   = CW'(r_ps) + CW'({w_groups, 4'b0000});
    assign w_n_m1     = CW'(i_n_width) - CW'(1);

    assign o_row = {r_dg, r_lane};
    assign o_col = CW'(r_ps) + CW'({r_grp, r_cig});

    assign o_flags.hit  = (o_row < i_k_depth) && (o_col < CW'(i_n_width));
    assign o_flags.last = (o_row == w_k_m1) && (o_col == w_n_m1);

    always_comb begin
        n_lane = r_lane;
        n_cig  = r_cig;
        n_grp  = r_grp;
        n_dg   = r_dg;
        n_ps   = r_ps;
        if (i_restart) begin
            n_lane = '0;
            n_cig  = '0;
            n_grp  = '0;
            n_dg   = '0;
            n_ps   = '0;
        end else if (i_advance) begin
            n_lane = r_lane + 2'd1;
            if (r_lane == pimu_pkg::LANE_LAST) begin
                n_cig = r_cig + 4'd1;
                if (r_cig == pimu_pkg::COL_LAST) begin
                    if (r_grp == w_grp_last) begin
                        n_grp = '0;
                        if (r_dg == w_dg_last) begin
                            n_dg = '0;
                            if (w_ps_sum >= CW'(i_n_width)) begin
                                n_ps = '0;
                            end else begin
                                n_ps = w_ps_sum[NW-1:0];
                            end
                        end else begin
                            n_dg = r_dg + DGW'(1);
                        end
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
            r_cig  <= '0;
            r_grp  <= '0;
            r_dg   <= '0;
            r_ps   <= '0;
        end else begin
            r_lane <= n_lane;
            r_cig  <= n_cig;
            r_grp  <= n_grp;
            r_dg   <= n_dg;
            r_ps   <= n_ps;
        end
    end

endmodule

// ===== rtl/pimu_offset.sv =====
// ----------------------------------------------------------------------------
// pimu_offset
// Result stage: one multiply-add for the destination offset, output
// register with valid/stall handshake.
// ----------------------------------------------------------------------------
module pimu_offset #(
    parameter int AW = 14,
    parameter int LW = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [pimu_pkg::BYTE_W-1:0]  i_value,
    input  logic [AW-1:0]                       i_mul_a,
    input  logic [AW-1:0]                       i_add_c,
    input  logic                                i_last,
    input  logic [LW-1:0]                       i_leading_dim,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pimu_pkg::BYTE_W-1:0]  o_value,
    output logic [pimu_pkg::OFFSET_W-1:0]       o_dest_offset,
    output logic                                o_last
);
    localparam int PW = AW + LW;
    localparam int FW = (PW + 1 > pimu_pkg::OFFSET_W) ? PW + 1 : pimu_pkg::OFFSET_W;

    logic [PW-1:0] w_prod;
    logic [FW-1:0] w_sum;

    logic                               r_valid;
    logic signed [pimu_pkg::BYTE_W-1:0] r_value;
    logic [pimu_pkg::OFFSET_W-1:0]      r_offset;
    logic                               r_last;

    assign w_prod  = PW'(i_mul_a) * PW'(i_leading_dim);
    assign w_sum   = FW'(w_prod) + FW'(i_add_c);
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_value  <= i_value;
            r_offset <= w_sum[pimu_pkg::OFFSET_W-1:0];
            r_last   <= i_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_value       = r_value;
    assign o_dest_offset = r_offset;
    assign o_last        = r_last;

endmodule

// ===== rtl/packed_int8_matrix_unpacker.sv =====
// ----------------------------------------------------------------------------
// packed_int8_matrix_unpacker
// Turns a packed int8 matrix stream back into elements with destination
// offsets.
// ----------------------------------------------------------------------------
// One packed byte is accepted per cycle while the output is not stalled; a
// byte in the matrix passes the stage-one and result-stage registers and
// leaves with its row- or column-major offset; padding bytes are dropped. The
// rate is set by the result stage, which does one offset multiply-add per
// cycle. Any configuration write restarts the traversal at the first byte.
// ----------------------------------------------------------------------------
module packed_int8_matrix_unpacker #(
    parameter int MAX_K_DEPTH     = 4096,
    parameter int MAX_N_WIDTH     = 4096,
    parameter int MAX_LEADING_DIM = 65535
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pimu_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [pimu_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [pimu_pkg::BYTE_W-1:0]    i_packed_byte,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [pimu_pkg::BYTE_W-1:0]    o_value,
    output logic [pimu_pkg::OFFSET_W-1:0]         o_dest_offset,
    output logic                                  o_last
);
    localparam int KMAX  = (MAX_K_DEPTH < 8191) ? MAX_K_DEPTH : 8191;
    localparam int NMAX  = (MAX_N_WIDTH < 8191) ? MAX_N_WIDTH : 8191;
    localparam int LMAX  = (MAX_LEADING_DIM < 65535) ? MAX_LEADING_DIM : 65535;
    localparam int KW    = $clog2(KMAX + 1);
    localparam int NW    = $clog2(((NMAX > 64) ? NMAX : 64) + 1);
    localparam int LW    = $clog2(((LMAX > 64) ? LMAX : 64) + 1);
    localparam int CW    = NW + 1;
    localparam int AW    = (CW > KW) ? CW : KW;

    logic [KW-1:0] r_k_depth;
    logic [NW-1:0] r_n_width;
    logic [LW-1:0] r_leading_dim;
    logic          r_column_major;

    logic [pimu_pkg::CFG_K_W-1:0]  w_k_raw;
    logic [pimu_pkg::CFG_N_W-1:0]  w_n_raw;
    logic [pimu_pkg::CFG_LD_W-1:0] w_ld_raw;
    logic [KW-1:0]                 n_k_depth;
    logic [NW-1:0]                 n_n_width;
    logic [LW-1:0]                 n_leading_dim;

    logic                  w_in_accept;
    logic [KW-1:0]         w_row;
    logic [CW-1:0]         w_col;
    pimu_pkg::t_walk_flags w_flags;
    logic                  w_s2_stall;

    logic                               r1_valid;
    logic signed [pimu_pkg::BYTE_W-1:0] r1_value;
    logic [AW-1:0]                      r1_mul_a;
    logic [AW-1:0]                      r1_add_c;
    logic                               r1_last;

    // saturate register writes into their legal ranges
    assign w_k_raw  = i_cfg_data[pimu_pkg::CFG_K_W-1:0];
    assign w_n_raw  = i_cfg_data[pimu_pkg::CFG_N_W-1:0];
    assign w_ld_raw = i_cfg_data[pimu_pkg::CFG_LD_W-1:0];

    always_comb begin
        if (w_k_raw == '0) begin
            n_k_depth = KW'(1);
        end else if (32'(w_k_raw) > 32'(KMAX)) begin
            n_k_depth = KW'(KMAX);
        end else begin
            n_k_depth = KW'(w_k_raw);
        end
        if (w_n_raw == '0) begin
            n_n_width = NW'(1);
        end else if (32'(w_n_raw) > 32'(NMAX)) begin
            n_n_width = NW'(NMAX);
        end else begin
            n_n_width = NW'(w_n_raw);
        end
        if (w_ld_raw == '0) begin
            n_leading_dim = LW'(1);
        end else if (32'(w_ld_raw) > 32'(LMAX)) begin
            n_leading_dim = LW'(LMAX);
        end else begin
            n_leading_dim = LW'(w_ld_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_depth      <= KW'(pimu_pkg::RST_K_DEPTH);
            r_n_width      <= NW'(pimu_pkg::RST_N_WIDTH);
            r_leading_dim  <= LW'(pimu_pkg::RST_LEADING_DIM);
            r_column_major <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pimu_pkg::REG_K_DEPTH:      r_k_depth      <= n_k_depth;
                pimu_pkg::REG_N_WIDTH:      r_n_width      <= n_n_width;
                pimu_pkg::REG_LEADING_DIM:  r_leading_dim  <= n_leading_dim;
                pimu_pkg::REG_COLUMN_MAJOR: r_column_major <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_stall     = r1_valid && w_s2_stall;
    assign w_in_accept = i_valid && !o_stall;

    pimu_walk #(
        .KW (KW),
        .NW (NW)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_advance (w_in_accept),
        .i_k_depth (r_k_depth),
        .i_n_width (r_n_width),
        .o_row     (w_row),
        .o_col     (w_col),
        .o_flags   (w_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (!o_stall) begin
            r1_valid <= w_in_accept && w_flags.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r1_value <= i_packed_byte;
            r1_last  <= w_flags.last;
            if (r_column_major) begin
                r1_mul_a <= AW'(w_col);
                r1_add_c <= AW'(w_row);
            end else begin
                r1_mul_a <= AW'(w_row);
                r1_add_c <= AW'(w_col);
            end
        end
    end

    pimu_offset #(
        .AW (AW),
        .LW (LW)
    ) u_offset (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r1_valid),
        .o_stall       (w_s2_stall),
        .i_value       (r1_value),
        .i_mul_a       (r1_mul_a),
        .i_add_c       (r1_add_c),
        .i_last        (r1_last),
        .i_leading_dim (r_leading_dim),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_dest_offset (o_dest_offset),
        .o_last        (o_last)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the packed int8 matrix unpacker.
// ----------------------------------------------------------------------------
// Packed bytes are offered in random bursts. The traversal of panels, 16-column
// groups, columns and depth lanes is tracked here. Each accepted byte that lands
// inside the matrix queues the element, its destination offset and the last
// flag. Output words are checked in order against that queue while the
// receiver stalls on its own pattern, with one long hold-off. Registers are
// reprogrammed only between phases, once the unpacker has drained.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PANEL_COLS = 64;
    localparam int GROUP_COLS = 16;
    localparam int DEPTH_LANES = 4;
    localparam int RANDOM_BYTES = 1650;
    localparam logic [pimu_pkg::CFG_ADDR_W-1:0] FIRST_UNUSED_REG =
        pimu_pkg::REG_COLUMN_MAJOR + 1'b1;

    typedef struct {
        logic signed [pimu_pkg::BYTE_W-1:0] value;
        logic [pimu_pkg::OFFSET_W-1:0] offset;
        logic last;
    } t_unpacked_elem;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [pimu_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [pimu_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [pimu_pkg::BYTE_W-1:0] i_packed_byte = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [pimu_pkg::BYTE_W-1:0] o_value;
    logic [pimu_pkg::OFFSET_W-1:0] o_dest_offset;
    logic o_last;

    packed_int8_matrix_unpacker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_packed_byte (i_packed_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_dest_offset (o_dest_offset),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register shadow
    int depth_rows = pimu_pkg::RST_K_DEPTH;
    int width_cols = pimu_pkg::RST_N_WIDTH;
    int stride = pimu_pkg::RST_LEADING_DIM;
    logic col_major = 1'b0;

    // traversal position
    logic [1:0] lane_idx = '0;
    logic [3:0] col_idx = '0;
    logic [1:0] grp_idx = '0;
    logic [9:0] kgrp_idx = '0;
    int panel_col0 = 0;

    logic signed [pimu_pkg::BYTE_W-1:0] packed_bytes_q[$];
    t_unpacked_elem pending_elems[$];
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = 0;
    int mode_left = 0;

    function automatic int clamp_cfg(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_walk();
        lane_idx = '0;
        col_idx = '0;
        grp_idx = '0;
        kgrp_idx = '0;
        panel_col0 = 0;
    endfunction

    function automatic void apply_cfg(input logic [pimu_pkg::CFG_ADDR_W-1:0] addr,
                                      input logic [pimu_pkg::CFG_DATA_W-1:0] data);
        case (addr)
            pimu_pkg::REG_K_DEPTH: begin
                depth_rows = clamp_cfg(int'(data[pimu_pkg::CFG_K_W-1:0]), 4096);
            end
            pimu_pkg::REG_N_WIDTH: begin
                width_cols = clamp_cfg(int'(data[pimu_pkg::CFG_N_W-1:0]), 4096);
            end
            pimu_pkg::REG_LEADING_DIM: begin
                stride = clamp_cfg(int'(data[pimu_pkg::CFG_LD_W-1:0]), 65535);
            end
            pimu_pkg::REG_COLUMN_MAJOR: begin
                col_major = data[0];
            end
            default: begin
            end
        endcase
        restart_walk();
    endfunction

    function automatic void unpack_step(input logic signed [pimu_pkg::BYTE_W-1:0] b);
        int rem;
        int groups;
        int kgroups;
        int row;
        int col;
        longint off;
        t_unpacked_elem e;
        rem = (panel_col0 < width_cols) ? width_cols - panel_col0 : 0;
        if (rem >= PANEL_COLS) groups = PANEL_COLS / GROUP_COLS;
        else if (rem >= GROUP_COLS) groups = rem / GROUP_COLS;
        else groups = 1;
        kgroups = (depth_rows + DEPTH_LANES - 1) / DEPTH_LANES;
        row = int'(kgrp_idx) * DEPTH_LANES + int'(lane_idx);
        col = panel_col0 + int'(grp_idx) * GROUP_COLS + int'(col_idx);
        if (row < depth_rows && col < width_cols) begin
            if (col_major) off = longint'(col) * stride + row;
            else off = longint'(row) * stride + col;
            e.value = b;
            e.offset = off[pimu_pkg::OFFSET_W-1:0];
            e.last = (row == depth_rows - 1) && (col == width_cols - 1);
            pending_elems.push_back(e);
        end
        if (lane_idx != pimu_pkg::LANE_LAST) begin
            lane_idx = lane_idx + 1'b1;
        end else begin
            lane_idx = '0;
            if (col_idx != pimu_pkg::COL_LAST) begin
                col_idx = col_idx + 1'b1;
            end else begin
                col_idx = '0;
                if (int'(grp_idx) + 1 < groups) begin
                    grp_idx = grp_idx + 1'b1;
                end else begin
                    grp_idx = '0;
                    if (int'(kgrp_idx) + 1 < kgroups) begin
                        kgrp_idx = kgrp_idx + 1'b1;
                    end else begin
                        kgrp_idx = '0;
                        panel_col0 += groups * GROUP_COLS;
                        if (panel_col0 >= width_cols) panel_col0 = 0;
                    end
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // byte sender: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin : byte_sender
        logic next_valid;
        logic signed [pimu_pkg::BYTE_W-1:0] next_byte;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            next_valid = i_valid;
            next_byte = i_packed_byte;
            if (i_valid && !o_stall) begin
                unpack_step(i_packed_byte);
                bytes_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (packed_bytes_q.size() > 0) begin
                    next_valid = 1'b1;
                    next_byte = packed_bytes_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 4) == 0) begin
                        burst_left = $urandom_range(50, 200);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = $urandom_range(1, 6);
                    end
                end
            end
            i_valid <= next_valid;
            i_packed_byte <= next_byte;
        end
    end

    // receiver stall pattern, plus one long hold-off while bytes are backed up
    always @(posedge i_clk) begin : word_receiver
        logic next_stall;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!hold_done && results_seen > 20 && packed_bytes_q.size() > 100) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_stall = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: next_stall = 1'b0;
                    1: next_stall = ($urandom_range(0, 3) == 0);
                    2: next_stall = ($urandom_range(0, 3) != 0);
                    default: next_stall = mode_left[2];
                endcase
            end
            i_stall <= next_stall;
        end
    end

    always @(posedge i_clk) begin : word_monitor
        t_unpacked_elem want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_elems.size() == 0) begin
                report_mismatch($sformatf("unexpected word: value %0d offset %0d last %0b",
                                          o_value, o_dest_offset, o_last));
            end else begin
                want = pending_elems.pop_front();
                if (o_value !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              o_value, want.value));
                if (o_dest_offset !== want.offset)
                    report_mismatch($sformatf("dest_offset %0d, expected %0d",
                                              o_dest_offset, want.offset));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b at offset %0d",
                                              o_last, want.last, want.offset));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [pimu_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [pimu_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_cfg(addr, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_byte(input logic signed [pimu_pkg::BYTE_W-1:0] b);
        packed_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_random_bytes(input int count);
        repeat (count) queue_byte(pimu_pkg::BYTE_W'($urandom));
    endtask

    // all bytes taken, all words out, then room for trailing padding bytes
    task automatic settle();
        while (bytes_accepted != bytes_queued || pending_elems.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic randomize_regs();
        int pick;
        int writes;
        writes = 0;
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: write_reg(pimu_pkg::REG_K_DEPTH,
                             pimu_pkg::CFG_DATA_W'($urandom_range(0, 1) ? 8191 : 4096));
                1: write_reg(pimu_pkg::REG_K_DEPTH, 0);
                2: write_reg(pimu_pkg::REG_K_DEPTH, 1);
                3: write_reg(pimu_pkg::REG_K_DEPTH,
                             pimu_pkg::CFG_DATA_W'($urandom_range(8192, 65535)));
                default: write_reg(pimu_pkg::REG_K_DEPTH,
                                   pimu_pkg::CFG_DATA_W'($urandom_range(1, 13)));
            endcase
            writes++;
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: write_reg(pimu_pkg::REG_N_WIDTH,
                             pimu_pkg::CFG_DATA_W'($urandom_range(4096, 8191)));
                1: write_reg(pimu_pkg::REG_N_WIDTH,
                             pimu_pkg::CFG_DATA_W'($urandom_range(0, 1)));
                2: write_reg(pimu_pkg::REG_N_WIDTH,
                             pimu_pkg::CFG_DATA_W'($urandom_range(65, 200)));
                default: write_reg(pimu_pkg::REG_N_WIDTH,
                                   pimu_pkg::CFG_DATA_W'($urandom_range(1, 80)));
            endcase
            writes++;
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: write_reg(pimu_pkg::REG_LEADING_DIM, 16'hFFFF);
                1: write_reg(pimu_pkg::REG_LEADING_DIM, 0);
                2: write_reg(pimu_pkg::REG_LEADING_DIM, 1);
                default: write_reg(pimu_pkg::REG_LEADING_DIM,
                                   pimu_pkg::CFG_DATA_W'($urandom_range(2, 65535)));
            endcase
            writes++;
        end
        if ($urandom_range(0, 3) != 0) begin
            write_reg(pimu_pkg::REG_COLUMN_MAJOR, pimu_pkg::CFG_DATA_W'($urandom));
            writes++;
        end
        if (writes == 0 || $urandom_range(0, 7) == 0)
            write_reg(FIRST_UNUSED_REG
                      + pimu_pkg::CFG_ADDR_W'($urandom_range(0, 15 - int'(FIRST_UNUSED_REG))),
                      pimu_pkg::CFG_DATA_W'($urandom));
    endtask

    initial begin : stimulus
        int random_bytes;
        int mat_bytes;
        int count;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, byte extremes
        queue_byte(-8'sd128);
        queue_byte(8'sd127);
        queue_byte(8'sd0);
        queue_byte(-8'sd1);
        queue_byte(8'sd1);
        queue_byte(8'sd85);
        queue_byte(-8'sd86);
        queue_byte(8'sd64);
        settle();

        // saturating writes: depth to max, width and stride to 1, column major
        write_reg(pimu_pkg::REG_K_DEPTH, 8191);
        write_reg(pimu_pkg::REG_N_WIDTH, 0);
        write_reg(pimu_pkg::REG_LEADING_DIM, 0);
        write_reg(pimu_pkg::REG_COLUMN_MAJOR, 1);
        queue_random_bytes(6);
        settle();

        // unused index restarts; depth 3 leaves the trailing lane unwritten
        write_reg(FIRST_UNUSED_REG, 16'h00A5);
        write_reg(pimu_pkg::REG_K_DEPTH, 3);
        queue_random_bytes(5);
        settle();

        write_reg(pimu_pkg::REG_COLUMN_MAJOR, 0);
        write_reg(pimu_pkg::REG_LEADING_DIM, 16'hFFFF);
        write_reg(pimu_pkg::REG_N_WIDTH, 4096);
        write_reg(pimu_pkg::REG_K_DEPTH, 5000);
        queue_random_bytes(4);
        settle();

        // dense phase first, so the long hold-off backs the input up
        write_reg(pimu_pkg::REG_K_DEPTH, 8);
        write_reg(pimu_pkg::REG_N_WIDTH, 48);
        write_reg(pimu_pkg::REG_LEADING_DIM,
                  pimu_pkg::CFG_DATA_W'($urandom_range(48, 65535)));
        write_reg(pimu_pkg::REG_COLUMN_MAJOR, pimu_pkg::CFG_DATA_W'($urandom));
        random_bytes = 2 * 8 * 48;
        queue_random_bytes(random_bytes);
        settle();

        while (random_bytes < RANDOM_BYTES) begin
            randomize_regs();
            mat_bytes = ((depth_rows + 3) / 4 * 4) * ((width_cols + 15) / 16 * 16);
            if (mat_bytes <= 512) begin
                count = mat_bytes * $urandom_range(1, 3);
                if ($urandom_range(0, 1) != 0) count += $urandom_range(1, mat_bytes - 1);
            end else begin
                count = $urandom_range(40, 400);
            end
            if (count > RANDOM_BYTES - random_bytes) count = RANDOM_BYTES - random_bytes;
            queue_random_bytes(count);
            random_bytes += count;
            settle();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pimu_pkg.sv
rtl/pimu_walk.sv
rtl/pimu_offset.sv
rtl/packed_int8_matrix_unpacker.sv
tb/sv/tb.sv
